[hw/rtl/pst_pkg.sv]
// ----------------------------------------------------------------------------
// Polyline stroke triangulator package
// Shared constants, datapath operation codes, the controller/datapath command
// and status structs, and the saturating vertex adder.
// ----------------------------------------------------------------------------
package pst_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   // CORDIC word width: holds the rotation start value (thickness / K) with growth.
   localparam int CW           = 58;
   localparam int NORM_BIT     = 40;
   localparam int THICK_W      = 31;
   localparam int COORD_W      = 32;
   localparam logic [31:0] KINV_Q32 = 32'(64'd2608131496 +
      (((64'd2608131496 * 64'd2) / 64'd3) >> (2 * CORDIC_STEPS)));
   localparam logic [THICK_W-1:0] THICK_RESET = THICK_W'(65536);

   typedef logic [3:0] op_type;
   localparam op_type OP_NOP   = 4'd0;
   localparam op_type OP_LOAD  = 4'd1;
   localparam op_type OP_FIRST = 4'd2;
   localparam op_type OP_DIFF  = 4'd3;
   localparam op_type OP_NORM  = 4'd4;
   localparam op_type OP_VEC   = 4'd5;
   localparam op_type OP_RINIT = 4'd6;
   localparam op_type OP_ROT   = 4'd7;
   localparam op_type OP_STORE = 4'd8;
   localparam op_type OP_EMIT  = 4'd9;
   localparam op_type OP_SHIFT = 4'd10;

   typedef struct packed {
      op_type            op;
      logic              diff_older;
      logic              store_a;
      logic              store_b;
      logic              seg1;
      logic              tri2;
      logic              last_tri;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic norm_done;
      logic zero_dir;
   } status_type;

   // Add or subtract two coordinates and clamp to the signed 32-bit range.
   function automatic logic signed [COORD_W-1:0] sat_add(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b,
      input logic                      sub);
      logic signed [COORD_W:0] s;
      s = sub ? ($signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b}))
              : ($signed({a[COORD_W-1], a}) + $signed({b[COORD_W-1], b}));
      if (s[COORD_W] != s[COORD_W-1]) begin
         sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         sat_add = s[COORD_W-1:0];
      end
   endfunction

endpackage

[hw/rtl/pst_datapath.sv]
// ----------------------------------------------------------------------------
// Polyline stroke triangulator datapath
// Point history, shared CORDIC shift-add unit, offset rounding and the
// triangle output register.
// ----------------------------------------------------------------------------
module pst_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  pst_pkg::cmd_type                  cmd,
   output pst_pkg::status_type               status,
   input  logic                              csr_write_enable,
   input  logic [pst_pkg::THICK_W-1:0]       csr_write_data,
   input  logic signed [pst_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [pst_pkg::COORD_W-1:0] req_point_y,
   output logic signed [pst_pkg::COORD_W-1:0] rsp_vertex_a_x,
   output logic signed [pst_pkg::COORD_W-1:0] rsp_vertex_a_y,
   output logic signed [pst_pkg::COORD_W-1:0] rsp_vertex_b_x,
   output logic signed [pst_pkg::COORD_W-1:0] rsp_vertex_b_y,
   output logic signed [pst_pkg::COORD_W-1:0] rsp_vertex_c_x,
   output logic signed [pst_pkg::COORD_W-1:0] rsp_vertex_c_y,
   output logic                              rsp_last_triangle
);
   import pst_pkg::*;

   logic [THICK_W-1:0]        thick_ff;
   logic [62:0]               prod_ff;
   logic signed [COORD_W-1:0] p_x_ff, p_y_ff, new_x_ff, new_y_ff, old_x_ff, old_y_ff;
   logic signed [COORD_W-1:0] pend_x_ff, pend_y_ff, a_x_ff, a_y_ff, b_x_ff, b_y_ff;
   logic signed [CW-1:0]      x_ff, y_ff, x_in, y_in;
   logic                      flip_ff, zero_ff;
   logic [CORDIC_STEPS-1:0]   dec_ff;
   logic signed [COORD_W-1:0] va_x_ff, va_y_ff, vb_x_ff, vb_y_ff, vc_x_ff, vc_y_ff;
   logic                      last_ff;

   logic signed [COORD_W:0]   dx, dy;
   logic signed [COORD_W-1:0] ref_x, ref_y;
   logic signed [CW-1:0]      vx, vy, sx, sy, abs_y, rx, ry, tx, ty;
   logic                      dir, flip;
   logic signed [COORD_W-1:0] res_x, res_y;
   logic signed [COORD_W-1:0] pi_x, pi_y, oi_x, oi_y, pj_x, pj_y, oj_x, oj_y;

   function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] t;
      t = (v + $signed(CW'(64'd1 << 23))) >>> 24;
      if (t > $signed(CW'(64'h7FFF_FFFF))) begin
         round_sat = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (t < -$signed(CW'(64'h8000_0000))) begin
         round_sat = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         round_sat = t[COORD_W-1:0];
      end
   endfunction

   // Direction difference and its left normal.
   always_comb begin
      ref_x  = cmd.diff_older ? old_x_ff : new_x_ff;
      ref_y  = cmd.diff_older ? old_y_ff : new_y_ff;
      dx     = $signed({p_x_ff[COORD_W-1], p_x_ff}) - $signed({ref_x[COORD_W-1], ref_x});
      dy     = $signed({p_y_ff[COORD_W-1], p_y_ff}) - $signed({ref_y[COORD_W-1], ref_y});
      vx     = -CW'(dy);
      vy     = CW'(dx);
      flip   = vx[CW-1];
      status.zero_dir = (dx == '0) && (dy == '0);
      abs_y  = y_ff[CW-1] ? -y_ff : y_ff;
      status.norm_done = (x_ff[CW-1:NORM_BIT] != '0) || (abs_y[CW-1:NORM_BIT] != '0);
   end

   // Shared CORDIC step: vectoring picks the direction from y, rotation replays it.
   always_comb begin
      sx  = x_ff >>> cmd.step;
      sy  = y_ff >>> cmd.step;
      dir = (cmd.op == OP_VEC) ? ~y_ff[CW-1] : ~dec_ff[cmd.step];
      x_in = x_ff;
      y_in = y_ff;
      case (cmd.op)
         OP_DIFF: begin
            x_in = flip ? -vx : vx;
            y_in = flip ? -vy : vy;
         end
         OP_NORM: begin
            x_in = x_ff <<< 1;
            y_in = y_ff <<< 1;
         end
         OP_VEC, OP_ROT: begin
            x_in = dir ? x_ff + sy : x_ff - sy;
            y_in = dir ? y_ff - sx : y_ff + sx;
         end
         OP_RINIT: begin
            x_in = $signed(CW'(prod_ff[62:8]));
            y_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rx    = flip_ff ? -x_ff : x_ff;
      ry    = flip_ff ? -y_ff : y_ff;
      tx    = rx;
      ty    = ry;
      res_x = zero_ff ? '0 : round_sat(tx);
      res_y = zero_ff ? $signed({1'b0, thick_ff}) : round_sat(ty);
      pi_x  = cmd.seg1 ? new_x_ff : old_x_ff;
      pi_y  = cmd.seg1 ? new_y_ff : old_y_ff;
      oi_x  = cmd.seg1 ? a_x_ff : pend_x_ff;
      oi_y  = cmd.seg1 ? a_y_ff : pend_y_ff;
      pj_x  = cmd.seg1 ? p_x_ff : new_x_ff;
      pj_y  = cmd.seg1 ? p_y_ff : new_y_ff;
      oj_x  = cmd.seg1 ? b_x_ff : a_x_ff;
      oj_y  = cmd.seg1 ? b_y_ff : a_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thick_ff <= THICK_RESET;
      end else if (csr_write_enable) begin
         thick_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 63'(thick_ff) * 63'(KINV_Q32);
      x_ff    <= x_in;
      y_ff    <= y_in;
      case (cmd.op)
         OP_LOAD: begin
            p_x_ff <= req_point_x;
            p_y_ff <= req_point_y;
         end
         OP_FIRST: begin
            new_x_ff <= p_x_ff;
            new_y_ff <= p_y_ff;
         end
         OP_DIFF: begin
            flip_ff <= flip;
            zero_ff <= status.zero_dir;
         end
         OP_VEC: begin
            dec_ff[cmd.step] <= ~y_ff[CW-1];
         end
         OP_STORE: begin
            if (cmd.store_a) begin
               a_x_ff <= res_x;
               a_y_ff <= res_y;
            end
            if (cmd.store_b) begin
               b_x_ff <= res_x;
               b_y_ff <= res_y;
            end
         end
         OP_SHIFT: begin
            pend_x_ff <= a_x_ff;
            pend_y_ff <= a_y_ff;
            old_x_ff  <= new_x_ff;
            old_y_ff  <= new_y_ff;
            new_x_ff  <= p_x_ff;
            new_y_ff  <= p_y_ff;
         end
         OP_EMIT: begin
            // First triangle: (pi+oi, pi-oi, pj-oj); second: (pj-oj, pj+oj, pi+oi).
            va_x_ff <= cmd.tri2 ? sat_add(pj_x, oj_x, 1'b1) : sat_add(pi_x, oi_x, 1'b0);
            va_y_ff <= cmd.tri2 ? sat_add(pj_y, oj_y, 1'b1) : sat_add(pi_y, oi_y, 1'b0);
            vb_x_ff <= cmd.tri2 ? sat_add(pj_x, oj_x, 1'b0) : sat_add(pi_x, oi_x, 1'b1);
            vb_y_ff <= cmd.tri2 ? sat_add(pj_y, oj_y, 1'b0) : sat_add(pi_y, oi_y, 1'b1);
            vc_x_ff <= cmd.tri2 ? sat_add(pi_x, oi_x, 1'b0) : sat_add(pj_x, oj_x, 1'b1);
            vc_y_ff <= cmd.tri2 ? sat_add(pi_y, oi_y, 1'b0) : sat_add(pj_y, oj_y, 1'b1);
            last_ff <= cmd.last_tri;
         end
         default: begin
         end
      endcase
   end

   assign rsp_vertex_a_x    = va_x_ff;
   assign rsp_vertex_a_y    = va_y_ff;
   assign rsp_vertex_b_x    = vb_x_ff;
   assign rsp_vertex_b_y    = vb_y_ff;
   assign rsp_vertex_c_x    = vc_x_ff;
   assign rsp_vertex_c_y    = vc_y_ff;
   assign rsp_last_triangle = last_ff;

endmodule

[hw/rtl/pst_ctrl.sv]
// ----------------------------------------------------------------------------
// Polyline stroke triangulator controller
// Sequences point intake, offset computation and triangle emission.
// ----------------------------------------------------------------------------
module pst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_last_point,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pst_pkg::cmd_type     cmd,
   input  pst_pkg::status_type  status
);
   import pst_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FIRST = 4'd1;
   localparam logic [3:0] S_DIFF  = 4'd2;
   localparam logic [3:0] S_NORM  = 4'd3;
   localparam logic [3:0] S_VEC   = 4'd4;
   localparam logic [3:0] S_RINIT = 4'd5;
   localparam logic [3:0] S_ROT   = 4'd6;
   localparam logic [3:0] S_STORE = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;
   localparam logic [3:0] S_SHIFT = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        seen_ff, seen_in;
   logic              last_ff, last_in, pass_ff, pass_in, tri_ff, tri_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              far_seg, step_end;

   // The near segment (older to newer) is only built in the first pass with two points kept.
   assign far_seg  = !((seen_ff == 2'd2) && !pass_ff);
   assign step_end = (step_ff == STEP_W'(CORDIC_STEPS - 1));

   always_comb begin
      state_in     = state_ff;
      seen_in      = seen_ff;
      last_in      = last_ff;
      pass_in      = pass_ff;
      tri_in       = tri_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.step     = step_ff;
      cmd.diff_older = !far_seg;
      cmd.seg1     = far_seg;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               last_in  = req_last_point;
               pass_in  = 1'b0;
               state_in = (seen_ff == 2'd0) ? S_FIRST : S_DIFF;
            end
         end
         S_FIRST: begin
            if (!last_ff) begin
               cmd.op  = OP_FIRST;
               seen_in = 2'd1;
            end
            state_in = S_IDLE;
         end
         S_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = status.zero_dir ? S_STORE : S_NORM;
         end
         S_NORM: begin
            if (status.norm_done) begin
               step_in  = '0;
               state_in = S_VEC;
            end else begin
               cmd.op = OP_NORM;
            end
         end
         S_VEC: begin
            cmd.op = OP_VEC;
            if (step_end) begin
               step_in  = '0;
               state_in = S_RINIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_RINIT: begin
            cmd.op   = OP_RINIT;
            state_in = S_ROT;
         end
         S_ROT: begin
            cmd.op = OP_ROT;
            if (step_end) begin
               step_in  = '0;
               state_in = S_STORE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_STORE: begin
            cmd.op      = OP_STORE;
            cmd.store_a = !((seen_ff == 2'd2) && pass_ff);
            cmd.store_b = ((seen_ff == 2'd1) && last_ff) || ((seen_ff == 2'd2) && pass_ff);
            tri_in      = 1'b0;
            state_in    = ((seen_ff == 2'd1) && !last_ff) ? S_SHIFT : S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_EMIT;
               cmd.tri2     = tri_ff;
               cmd.last_tri = tri_ff && far_seg;
               rsp_valid_in = 1'b1;
               tri_in       = 1'b1;
               if (tri_ff) begin
                  if (far_seg) begin
                     seen_in  = 2'd0;
                     pass_in  = 1'b0;
                     state_in = S_IDLE;
                  end else if (last_ff) begin
                     pass_in  = 1'b1;
                     state_in = S_DIFF;
                  end else begin
                     state_in = S_SHIFT;
                  end
               end
            end
         end
         S_SHIFT: begin
            cmd.op   = OP_SHIFT;
            seen_in  = 2'd2;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seen_ff      <= 2'd0;
         last_ff      <= 1'b0;
         pass_ff      <= 1'b0;
         tri_ff       <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         last_ff      <= last_in;
         pass_ff      <= pass_in;
         tri_ff       <= tri_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/polyline_stroke_triangulator.sv]
// ----------------------------------------------------------------------------
// Polyline stroke triangulator
// Turns a stream of polyline points into stroke triangles, two per segment.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake          Beat contents
//   req_      in         valid / ready      point x, point y, last point flag
//   rsp_      out        valid / ready      three vertices, last triangle flag
//   csr_      in         write enable only  thickness (unsigned Q15.16)
//
// When an offset is needed, a point beat runs the difference step, one
// normalizing shift per cycle, CORDIC_STEPS vectoring and CORDIC_STEPS
// rotation steps in the single shared shift-add unit, the rotation start
// and store steps and one emit step per triangle. A last point that closes
// two segments runs the offset unit twice. Reset is synchronous and active
// high. A stalled result side holds the controller in its emit state, and no
// new point is taken until all triangles of the current point are loaded.
module polyline_stroke_triangulator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [pst_pkg::THICK_W-1:0]        csr_write_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [pst_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [pst_pkg::COORD_W-1:0] req_point_y,
   input  logic                               req_last_point,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [pst_pkg::COORD_W-1:0] rsp_vertex_a_x,
   output logic signed [pst_pkg::COORD_W-1:0] rsp_vertex_a_y,
   output logic signed [pst_pkg::COORD_W-1:0] rsp_vertex_b_x,
   output logic signed [pst_pkg::COORD_W-1:0] rsp_vertex_b_y,
   output logic signed [pst_pkg::COORD_W-1:0] rsp_vertex_c_x,
   output logic signed [pst_pkg::COORD_W-1:0] rsp_vertex_c_y,
   output logic                               rsp_last_triangle
);
   import pst_pkg::*;

   // Commands flow from the controller; the datapath reports the zero
   // direction case and the end of normalization.
   cmd_type    cmd;
   status_type status;

   pst_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .cmd            (cmd),
      .status         (status)
   );

   pst_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .rsp_vertex_a_x    (rsp_vertex_a_x),
      .rsp_vertex_a_y    (rsp_vertex_a_y),
      .rsp_vertex_b_x    (rsp_vertex_b_x),
      .rsp_vertex_b_y    (rsp_vertex_b_y),
      .rsp_vertex_c_x    (rsp_vertex_c_x),
      .rsp_vertex_c_y    (rsp_vertex_c_y),
      .rsp_last_triangle (rsp_last_triangle)
   );

endmodule

[hw/rtl/pst_checker.sv]
// ----------------------------------------------------------------------------
// Polyline stroke triangulator checker
// Port-level properties of the triangulator, bound to the top level.
// ----------------------------------------------------------------------------
module pst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_vertex_a_x,
   input logic        rsp_last_triangle
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex_a_x))
      else $error("result beat dropped or changed while stalled");

   a_one_point: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second point taken before the first was processed");

   a_last_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_last_triangle))
      else $error("last triangle flag changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind polyline_stroke_triangulator pst_checker u_pst_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_vertex_a_x    (rsp_vertex_a_x),
   .rsp_last_triangle (rsp_last_triangle)
);

[sim/polyline_stroke_triangulator_test.sv]
// ----------------------------------------------------------------------------
// Polyline stroke triangulator testbench
// Feeds polylines through the request channel, predicts stroke triangles with
// a local fixed-point CORDIC model or types them in, and checks each response
// beat in order while both sides idle at random and the thickness is swept.
// ----------------------------------------------------------------------------
module polyline_stroke_triangulator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  COORD_W   = pst_pkg::COORD_W;
   localparam int  THICK_W   = pst_pkg::THICK_W;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;
   // Two offset computations plus the triangles of a closing point.
   localparam int  SETTLE_CYCLES = 400;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct {
      coord_type ax, ay, bx, by, cx, cy;
      logic      last;
   } triangle_type;

   typedef struct {
      coord_type    x, y;
      logic         last;
      int           n_typed;   // -1 when the predictor supplies the triangles
      triangle_type typed [2];
   } point_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [THICK_W-1:0]  csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   coord_type           req_point_x = '0;
   coord_type           req_point_y = '0;
   logic                req_last_point = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   coord_type           rsp_vertex_a_x, rsp_vertex_a_y;
   coord_type           rsp_vertex_b_x, rsp_vertex_b_y;
   coord_type           rsp_vertex_c_x, rsp_vertex_c_y;
   logic                rsp_last_triangle;

   polyline_stroke_triangulator dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_last_point    (req_last_point),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vertex_a_x    (rsp_vertex_a_x),
      .rsp_vertex_a_y    (rsp_vertex_a_y),
      .rsp_vertex_b_x    (rsp_vertex_b_x),
      .rsp_vertex_b_y    (rsp_vertex_b_y),
      .rsp_vertex_c_x    (rsp_vertex_c_x),
      .rsp_vertex_c_y    (rsp_vertex_c_y),
      .rsp_last_triangle (rsp_last_triangle)
   );

   always #2 clock = ~clock;

   // Shadow copy of the block's state, advanced once per accepted point beat.
   logic [THICK_W-1:0] stroke_width = pst_pkg::THICK_RESET;
   longint             prev2_x, prev2_y, prev1_x, prev1_y;
   longint             held_off_x, held_off_y;
   int                 point_count;

   triangle_type       triangle_q [$];
   point_row_type      directed_rows [$];
   int                 error_count;

   function automatic longint clamp32(input longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   // Offset of thickness along the unit left normal of direction (dx, dy).
   // A vectoring pass records the angle as decisions, and a rotation pass
   // spins the scaled thickness by the same angle.
   task automatic normal_offset(input longint dx, input longint dy,
                                output longint ox, output longint oy);
      longint     vx, vy, mag, nx;
      logic       flipped;
      logic [31:0] turns;
      longint unsigned prod;
      flipped = 1'b0;
      turns   = '0;
      if (dx == 0 && dy == 0) begin
         ox = 0;
         oy = longint'(stroke_width);
         return;
      end
      vx = -dy;
      vy = dx;
      if (vx < 0) begin
         vx = -vx;
         vy = -vy;
         flipped = 1'b1;
      end
      mag = (vx > (vy < 0 ? -vy : vy)) ? vx : (vy < 0 ? -vy : vy);
      while (mag < (64'sd1 <<< pst_pkg::NORM_BIT)) begin
         mag = mag * 2;
         vx  = vx * 2;
         vy  = vy * 2;
      end
      for (int i = 0; i < pst_pkg::CORDIC_STEPS; i++) begin
         if (vy >= 0) begin
            nx = vx + (vy >>> i);
            vy = vy - (vx >>> i);
            turns[i] = 1'b1;
         end else begin
            nx = vx - (vy >>> i);
            vy = vy + (vx >>> i);
         end
         vx = nx;
      end
      prod = longint'(stroke_width) * longint'(pst_pkg::KINV_Q32);
      vx = longint'(prod >> 8);
      vy = 0;
      for (int i = 0; i < pst_pkg::CORDIC_STEPS; i++) begin
         if (turns[i]) begin
            nx = vx - (vy >>> i);
            vy = vy + (vx >>> i);
         end else begin
            nx = vx + (vy >>> i);
            vy = vy - (vx >>> i);
         end
         vx = nx;
      end
      if (flipped) begin
         vx = -vx;
         vy = -vy;
      end
      ox = clamp32((vx + (64'sd1 <<< 23)) >>> 24);
      oy = clamp32((vy + (64'sd1 <<< 23)) >>> 24);
   endtask

   // Both triangles of the segment pi -> pj with offsets oi and oj.
   task automatic add_segment(input longint pix, input longint piy,
                              input longint oix, input longint oiy,
                              input longint pjx, input longint pjy,
                              input longint ojx, input longint ojy,
                              input logic closing, ref triangle_type tris [$]);
      triangle_type t;
      t.ax = coord_type'(clamp32(pix + oix)); t.ay = coord_type'(clamp32(piy + oiy));
      t.bx = coord_type'(clamp32(pix - oix)); t.by = coord_type'(clamp32(piy - oiy));
      t.cx = coord_type'(clamp32(pjx - ojx)); t.cy = coord_type'(clamp32(pjy - ojy));
      t.last = 1'b0;
      tris.push_back(t);
      t.ax = coord_type'(clamp32(pjx - ojx)); t.ay = coord_type'(clamp32(pjy - ojy));
      t.bx = coord_type'(clamp32(pjx + ojx)); t.by = coord_type'(clamp32(pjy + ojy));
      t.cx = coord_type'(clamp32(pix + oix)); t.cy = coord_type'(clamp32(piy + oiy));
      t.last = closing;
      tris.push_back(t);
   endtask

   // Advances the shadow state by one point and returns its triangles.
   task automatic stroke_point(input coord_type x, input coord_type y, input logic last,
                               ref triangle_type tris [$]);
      longint px, py, ax, ay, bx, by;
      px = longint'(x);
      py = longint'(y);
      if (point_count == 0) begin
         if (!last) begin
            prev1_x = px;
            prev1_y = py;
            point_count = 1;
         end
         return;
      end
      if (point_count == 1) begin
         normal_offset(px - prev1_x, py - prev1_y, ax, ay);
         if (last) begin
            add_segment(prev1_x, prev1_y, ax, ay, px, py, ax, ay, 1'b1, tris);
            point_count = 0;
            return;
         end
         point_count = 2;
      end else begin
         // Inner point: central difference spans the two neighbors.
         normal_offset(px - prev2_x, py - prev2_y, ax, ay);
         add_segment(prev2_x, prev2_y, held_off_x, held_off_y,
                     prev1_x, prev1_y, ax, ay, 1'b0, tris);
         if (last) begin
            normal_offset(px - prev1_x, py - prev1_y, bx, by);
            add_segment(prev1_x, prev1_y, ax, ay, px, py, bx, by, 1'b1, tris);
            point_count = 0;
            return;
         end
      end
      held_off_x = ax;
      held_off_y = ay;
      prev2_x = prev1_x;
      prev2_y = prev1_y;
      prev1_x = px;
      prev1_y = py;
   endtask

   // Mostly short gaps, a few long ones, and about half of the time none.
   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drives one point beat, waits for its acceptance, then records the
   // triangles it is expected to produce.
   task automatic send_point(input point_row_type row);
      int           gap;
      triangle_type tris [$];
      gap = gap_cycles();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_point_x    <= row.x;
      req_point_y    <= row.y;
      req_last_point <= row.last;
      do @(posedge clock); while (!req_ready);
      stroke_point(row.x, row.y, row.last, tris);
      if (row.n_typed >= 0) begin
         for (int i = 0; i < row.n_typed; i++) triangle_q.push_back(row.typed[i]);
      end else begin
         foreach (tris[i]) triangle_q.push_back(tris[i]);
      end
   endtask

   // The block is idle once every triangle has left and any point that made
   // no triangle has had time to finish its offset work.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (triangle_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_thickness(input logic [THICK_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      stroke_width = value;
   endtask

   task automatic add_row(input coord_type x, input coord_type y, input logic last);
      point_row_type row;
      row.x = x;
      row.y = y;
      row.last = last;
      row.n_typed = -1;
      directed_rows.push_back(row);
   endtask

   // A repeated final point has a zero direction, so its offset is exactly
   // (0, thickness) and the two triangles can be written down directly.
   task automatic add_zero_dir_pair(input coord_type x, input coord_type y);
      point_row_type row;
      longint        top, bot;
      top = clamp32(longint'(y) + 65536);
      bot = clamp32(longint'(y) - 65536);
      add_row(x, y, 1'b0);
      row.x = x;
      row.y = y;
      row.last = 1'b1;
      row.n_typed = 2;
      row.typed[0] = '{x, coord_type'(top), x, coord_type'(bot), x, coord_type'(bot), 1'b0};
      row.typed[1] = '{x, coord_type'(bot), x, coord_type'(top), x, coord_type'(top), 1'b1};
      directed_rows.push_back(row);
   endtask

   function automatic coord_type random_coord(input int style);
      case (style)
         0: return coord_type'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
         1: return coord_type'($urandom());
         default: return $urandom_range(0, 1) ? coord_type'(32'h7fff_ffff)
                                              : coord_type'(32'h8000_0000);
      endcase
   endfunction

   // One random polyline: most points are near each other, some span the full
   // range, some sit at the extremes and some repeat the previous point.
   task automatic send_random_polyline(ref int sent);
      int            length;
      point_row_type row;
      int            r;
      length = $urandom_range(1, 6);
      row.n_typed = -1;
      row.x = random_coord(0);
      row.y = random_coord(0);
      for (int i = 0; i < length; i++) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            row.x = coord_type'(longint'(row.x) + $signed($urandom_range(0, 8191)) - 4096);
            row.y = coord_type'(longint'(row.y) + $signed($urandom_range(0, 8191)) - 4096);
         end else if (r < 80) begin
            row.x = random_coord(1);
            row.y = random_coord(1);
         end else if (r < 90) begin
            row.x = random_coord(2);
            row.y = random_coord(2);
         end
         row.last = (i == length - 1);
         send_point(row);
         sent++;
      end
   endtask

   task automatic report_mismatch(input string field, input coord_type got,
                                  input coord_type want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      error_count++;
   endtask

   // The result side stalls in runs: each run holds ready low for a random gap.
   int stall_left;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_ready) stall_left <= gap_cycles();
      end
   end

   // Every response beat is checked against the oldest expected triangle.
   always @(posedge clock) begin
      triangle_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (triangle_q.size() == 0) begin
            $display("%0t response beat with no triangle expected", $realtime);
            error_count++;
         end else begin
            want = triangle_q.pop_front();
            if (rsp_vertex_a_x !== want.ax) report_mismatch("vertex_a_x", rsp_vertex_a_x, want.ax);
            if (rsp_vertex_a_y !== want.ay) report_mismatch("vertex_a_y", rsp_vertex_a_y, want.ay);
            if (rsp_vertex_b_x !== want.bx) report_mismatch("vertex_b_x", rsp_vertex_b_x, want.bx);
            if (rsp_vertex_b_y !== want.by) report_mismatch("vertex_b_y", rsp_vertex_b_y, want.by);
            if (rsp_vertex_c_x !== want.cx) report_mismatch("vertex_c_x", rsp_vertex_c_x, want.cx);
            if (rsp_vertex_c_y !== want.cy) report_mismatch("vertex_c_y", rsp_vertex_c_y, want.cy);
            if (rsp_last_triangle !== want.last)
               report_mismatch("last_triangle", coord_type'(rsp_last_triangle),
                               coord_type'(want.last));
         end
      end
   end

   initial begin
      #4ms;
      $display("polyline_stroke_triangulator_test: done, errors");
      $finish;
   end

   initial begin
      logic [THICK_W-1:0] widths [4];
      int sent;
      point_count = 0;
      error_count = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, at the reset thickness so the typed rows hold.
      add_zero_dir_pair(32'sd5, 32'sd5);
      add_row(32'sd7, 32'sd7, 1'b1);                              // lone point
      add_zero_dir_pair(32'sh7fff_ffff, 32'sh7fff_ffff);          // clamps high
      add_zero_dir_pair(32'sh8000_0000, 32'sh8000_0000);          // clamps low
      add_row(32'sd0, 32'sd0, 1'b0);                              // horizontal
      add_row(32'sh0001_0000, 32'sd0, 1'b1);
      add_row(32'sd0, 32'sd0, 1'b0);                              // leftward: flipped
      add_row(-32'sh0003_0000, 32'sh0001_0000, 1'b0);
      add_row(-32'sh0005_0000, -32'sh0002_0000, 1'b1);
      add_row(32'sh8000_0000, 32'sh8000_0000, 1'b0);              // full-range spans
      add_row(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
      add_row(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
      add_row(32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
      add_row(32'sd1, 32'sd0, 1'b0);                              // inner point repeats
      add_row(32'sd1, 32'sd0, 1'b0);
      add_row(32'sd1, 32'sd0, 1'b0);
      add_row(32'sd2, -32'sd1, 1'b1);
      foreach (directed_rows[i]) send_point(directed_rows[i]);
      wait_drained();

      // Random part across several thickness settings, extremes included.
      widths[0] = '0;
      widths[1] = {THICK_W{1'b1}};
      widths[2] = THICK_W'(1);
      widths[3] = THICK_W'($urandom());
      foreach (widths[p]) begin
         write_thickness(widths[p]);
         sent = 0;
         while (sent < 62) send_random_polyline(sent);
         wait_drained();
      end

      if (error_count == 0) begin
         $display("polyline_stroke_triangulator_test: done, clean");
      end else begin
         $display("polyline_stroke_triangulator_test: done, errors");
      end
      $finish;
   end

endmodule

[polyline_stroke_triangulator.f]
hw/rtl/pst_pkg.sv
hw/rtl/pst_datapath.sv
hw/rtl/pst_ctrl.sv
hw/rtl/polyline_stroke_triangulator.sv
hw/rtl/pst_checker.sv
sim/polyline_stroke_triangulator_test.sv
